### hw/rtl/mss_esc_pkg.sv
// ----------------------------------------------------------------------------
// mss_esc_pkg: shared types and constants for the stall escalator
// Word layouts of both channels, register indexes, action codes and the
// teleport distance lookup.
// ----------------------------------------------------------------------------
package mss_esc_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int COORD_BITS = 24;
    localparam int SLOT_W     = 4;
    localparam int THR_W      = 16;
    localparam int CNT_W      = 8;
    localparam int TELE_W     = 4;
    localparam int DIST_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Per-axis distance magnitude clamp; the threshold always lies below it
    localparam int MAG_W      = 17;
    localparam logic [MAG_W-1:0] DIFF_CLAMP = MAG_W'(65536);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHECKS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RECOVERY = CFG_IDX_W'(1);

    localparam logic [CNT_W-1:0] MAX_CHECKS_RST   = CNT_W'(5);
    localparam logic [CNT_W-1:0] MAX_RECOVERY_RST = CNT_W'(3);

    // Item functions
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    // Result actions
    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_SOFT     = 2'd1;
    localparam logic [1:0] ACT_TELEPORT = 2'd2;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [TELE_W-1:0] TELE_MAX = {TELE_W{1'b1}};

    localparam logic [DIST_W-1:0] DIST_FAR  = DIST_W'(2000);
    localparam logic [DIST_W-1:0] DIST_MID  = DIST_W'(1000);
    localparam logic [DIST_W-1:0] DIST_NEAR = DIST_W'(500);
    localparam logic [DIST_W-1:0] DIST_MIN  = DIST_W'(250);

    typedef struct packed {
        logic                         func;
        logic [SLOT_W-1:0]            slot;
        logic                         actor_present;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [THR_W-1:0]             move_threshold;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [DIST_W-1:0] teleport_distance;
        logic [CNT_W-1:0]  recovery_count;
        logic [CNT_W-1:0]  stall_count;
    } out_word_t;

    // Teleport distance shrinks as teleports pile up
    function automatic logic [DIST_W-1:0] dist_of(logic [TELE_W-1:0] t);
        logic [DIST_W-1:0] d;
        if (t <= TELE_W'(1)) begin
            d = DIST_FAR;
        end else if (t == TELE_W'(2)) begin
            d = DIST_MID;
        end else if (t == TELE_W'(3)) begin
            d = DIST_NEAR;
        end else begin
            d = DIST_MIN;
        end
        return d;
    endfunction

endpackage

### hw/rtl/multi_slot_stall_escalator_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_stall_escalator_unit: per-slot stall detector with escalation
// Tracks the last position and stall/recovery/teleport counters of each
// slot and orders soft recovery or teleport when a slot stops moving.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+---------------------------
//  s_       | in        | s_valid / s_ready  | in_word_t  (check / reset)
//  m_       | out       | m_valid / m_ready  | out_word_t (action, counts)
//  cfg_     | in        | cfg_wr_en          | cfg_index, cfg_data
//
//  One word per cycle sustained while the result register is not stalled; each
//  result follows its word through the input register and then the result
//  register, which loads once it is free.
//  The rate is set by the read-modify-write of one slot record, written back
//  with the result, so back-to-back words on the same slot see fresh state.
//  Reset clears both valid flags, all slot valid bits and the counters at once.
//  A stalled result register holds, and the input register then fills and
//  drops s_ready.
// ----------------------------------------------------------------------------
module multi_slot_stall_escalator_unit
    import mss_esc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_word_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_word_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int D2_W       = SQ_W + 2;
    localparam int THR2_W     = 2 * THR_W;

    // Absolute axis difference, clamped so the square stays narrow
    function automatic logic [MAG_W-1:0] clamp_mag(logic [COORD_BITS-1:0] a,
                                                   logic [COORD_BITS-1:0] b);
        logic [DIFF_W-1:0] d;
        logic [DIFF_W-1:0] m;
        logic [MAG_W-1:0]  r;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        m = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
        if (m > DIFF_W'(DIFF_CLAMP)) begin
            r = DIFF_CLAMP;
        end else begin
            r = m[MAG_W-1:0];
        end
        return r;
    endfunction

    logic [CNT_W-1:0] max_checks_reg;
    logic [CNT_W-1:0] max_recovery_reg;

    logic      in_valid_reg;
    in_word_t  in_data_reg;
    logic      out_valid_reg;
    out_word_t out_data_reg;

    logic                  slot_valid_reg [SLOT_COUNT];
    logic [COORD_BITS-1:0] last_x_reg     [SLOT_COUNT];
    logic [COORD_BITS-1:0] last_y_reg     [SLOT_COUNT];
    logic [COORD_BITS-1:0] last_z_reg     [SLOT_COUNT];
    logic [CNT_W-1:0]      stalled_reg    [SLOT_COUNT];
    logic [CNT_W-1:0]      recov_reg      [SLOT_COUNT];
    logic [TELE_W-1:0]     tele_reg       [SLOT_COUNT];

    logic                  advance;
    logic                  in_range;
    logic [SLOT_IDX_W-1:0] idx;

    logic                  cur_valid;
    logic [CNT_W-1:0]      cur_stall;
    logic [CNT_W-1:0]      cur_recov;
    logic [TELE_W-1:0]     cur_tele;

    logic [MAG_W-1:0]  mag_x;
    logic [MAG_W-1:0]  mag_y;
    logic [MAG_W-1:0]  mag_z;
    logic [SQ_W-1:0]   sq_x;
    logic [SQ_W-1:0]   sq_y;
    logic [SQ_W-1:0]   sq_z;
    logic [D2_W-1:0]   d2;
    logic [THR2_W-1:0] thr2;
    logic              moved;

    logic              wr_slot;
    logic              wr_pos;
    logic              valid_next;
    logic [CNT_W-1:0]  stall_next;
    logic [CNT_W-1:0]  recov_next;
    logic [TELE_W-1:0] tele_next;
    logic [1:0]        action_next;
    logic [CNT_W-1:0]  stall_inc;
    logic [CNT_W-1:0]  recov_inc;
    out_word_t         out_data_next;

    // Handshake: the work stage moves when the result register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_checks_reg   <= MAX_CHECKS_RST;
            max_recovery_reg <= MAX_RECOVERY_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_MAX_CHECKS) begin
                max_checks_reg <= cfg_data[CNT_W-1:0];
            end else if (cfg_index == CFG_MAX_RECOVERY) begin
                max_recovery_reg <= cfg_data[CNT_W-1:0];
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Read the addressed slot record
    assign in_range  = (32'(in_data_reg.slot) < 32'(SLOT_COUNT));
    assign idx       = SLOT_IDX_W'(in_data_reg.slot);
    assign cur_valid = slot_valid_reg[idx];
    assign cur_stall = stalled_reg[idx];
    assign cur_recov = recov_reg[idx];
    assign cur_tele  = tele_reg[idx];

    // Squared distance against squared threshold
    assign mag_x = clamp_mag(in_data_reg.pos_x, last_x_reg[idx]);
    assign mag_y = clamp_mag(in_data_reg.pos_y, last_y_reg[idx]);
    assign mag_z = clamp_mag(in_data_reg.pos_z, last_z_reg[idx]);
    assign sq_x  = SQ_W'(mag_x) * SQ_W'(mag_x);
    assign sq_y  = SQ_W'(mag_y) * SQ_W'(mag_y);
    assign sq_z  = SQ_W'(mag_z) * SQ_W'(mag_z);
    assign d2    = D2_W'(sq_x) + D2_W'(sq_y) + D2_W'(sq_z);
    assign thr2  = THR2_W'(in_data_reg.move_threshold) * THR2_W'(in_data_reg.move_threshold);
    assign moved = (d2 >= D2_W'(thr2));

    assign stall_inc = (cur_stall < CNT_MAX) ? cur_stall + CNT_W'(1) : cur_stall;
    assign recov_inc = (cur_recov < CNT_MAX) ? cur_recov + CNT_W'(1) : cur_recov;

    // Next slot record and action
    always_comb begin
        wr_slot     = 1'b0;
        wr_pos      = 1'b0;
        valid_next  = cur_valid;
        stall_next  = cur_stall;
        recov_next  = cur_recov;
        tele_next   = cur_tele;
        action_next = ACT_NONE;
        if (in_data_reg.func == FUNC_RESET) begin
            wr_slot    = 1'b1;
            wr_pos     = in_data_reg.actor_present;
            valid_next = in_data_reg.actor_present;
            stall_next = '0;
            recov_next = '0;
            tele_next  = '0;
        end else if (in_data_reg.actor_present) begin
            wr_slot    = 1'b1;
            wr_pos     = 1'b1;
            valid_next = 1'b1;
            if (!cur_valid) begin
                stall_next = '0;
                recov_next = '0;
                tele_next  = '0;
            end else if (moved) begin
                stall_next = '0;
                tele_next  = '0;
            end else if (stall_inc >= max_checks_reg) begin
                stall_next = '0;
                if (recov_inc < max_recovery_reg) begin
                    recov_next  = recov_inc;
                    action_next = ACT_SOFT;
                end else begin
                    recov_next  = '0;
                    tele_next   = (cur_tele < TELE_MAX) ? cur_tele + TELE_W'(1) : cur_tele;
                    action_next = ACT_TELEPORT;
                end
            end else begin
                stall_next = stall_inc;
            end
        end

        if (in_range) begin
            out_data_next.action            = action_next;
            out_data_next.teleport_distance = dist_of(tele_next);
            out_data_next.recovery_count    = recov_next;
            out_data_next.stall_count       = stall_next;
        end else begin
            wr_slot                         = 1'b0;
            wr_pos                          = 1'b0;
            out_data_next.action            = ACT_NONE;
            out_data_next.teleport_distance = DIST_FAR;
            out_data_next.recovery_count    = '0;
            out_data_next.stall_count       = '0;
        end
    end

    // Write back the slot record; positions need no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_valid_reg[i] <= 1'b0;
                stalled_reg[i]    <= '0;
                recov_reg[i]      <= '0;
                tele_reg[i]       <= '0;
            end
        end else if (advance && wr_slot) begin
            slot_valid_reg[idx] <= valid_next;
            stalled_reg[idx]    <= stall_next;
            recov_reg[idx]      <= recov_next;
            tele_reg[idx]       <= tele_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && wr_pos) begin
            last_x_reg[idx] <= in_data_reg.pos_x;
            last_y_reg[idx] <= in_data_reg.pos_y;
            last_z_reg[idx] <= in_data_reg.pos_z;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // A teleport always leaves both counters cleared
    a_teleport_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.action == ACT_TELEPORT) |->
            (m_data.recovery_count == '0 && m_data.stall_count == '0))
        else $error("teleport result with nonzero counters");

    // A soft recovery clears the stall count and leaves a recovery recorded
    a_soft_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.action == ACT_SOFT) |->
            (m_data.stall_count == '0 && m_data.recovery_count != '0))
        else $error("soft recovery result with inconsistent counters");

    // Input backpressure only comes from a full, stalled pipeline
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("s_ready low without a stalled result");

    // Teleport distance is one of the four steps
    a_dist_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.teleport_distance == DIST_FAR ||
                     m_data.teleport_distance == DIST_MID ||
                     m_data.teleport_distance == DIST_NEAR ||
                     m_data.teleport_distance == DIST_MIN))
        else $error("teleport distance off the step table");

endmodule
